>>> design/rcmf_pkg.sv
// Shared constants for the robot controller mode machine: widths, state codes, event codes.
`default_nettype none

package rcmf_pkg;

  localparam int unsigned CNT_W   = 25;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [3:0] ERROR_LEVEL_LIMIT = 4'd4;
  localparam logic [TICKS_W-1:0] ROBOT_TIMEOUT_RESET = 24'd100000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_VALID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_TIMEOUT    = 2'd2;

  // Event codes.
  localparam logic [2:0] EV_TICK     = 3'd0;
  localparam logic [2:0] EV_ESTOP    = 3'd1;
  localparam logic [2:0] EV_RESET    = 3'd2;
  localparam logic [2:0] EV_SHUTDOWN = 3'd3;
  localparam logic [2:0] EV_TEACH    = 3'd4;
  localparam logic [2:0] EV_RUN      = 3'd5;
  localparam logic [2:0] EV_MACRO    = 3'd6;

  // Controller states.
  localparam logic [2:0] CT_INIT               = 3'd0;
  localparam logic [2:0] CT_ESTOP              = 3'd1;
  localparam logic [2:0] CT_ESTOP_TO_ENGAGED   = 3'd2;
  localparam logic [2:0] CT_ENGAGED            = 3'd3;
  localparam logic [2:0] CT_ANY_TO_ESTOP       = 3'd4;
  localparam logic [2:0] CT_ESTOP_TO_TERMINATE = 3'd5;
  localparam logic [2:0] CT_TERMINATED         = 3'd6;

  // Robot states.
  localparam logic [2:0] RB_IDLE             = 3'd0;
  localparam logic [2:0] RB_IDLE_TO_RUNNING  = 3'd1;
  localparam logic [2:0] RB_RUNNING          = 3'd2;
  localparam logic [2:0] RB_RUNNING_TO_IDLE  = 3'd3;
  localparam logic [2:0] RB_IDLE_TO_TEACHING = 3'd4;
  localparam logic [2:0] RB_TEACHING         = 3'd5;
  localparam logic [2:0] RB_TEACHING_TO_IDLE = 3'd6;

  // Servo and interpreter codes.
  localparam logic [1:0] SRV_IDLE       = 2'd0;
  localparam logic [1:0] SRV_RUN        = 2'd1;
  localparam logic [1:0] INTERP_IDLE    = 2'd0;
  localparam logic [1:0] INTERP_EXEC    = 2'd1;

  // Status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_INVALID_OP    = 3'd1;
  localparam logic [2:0] ST_INVALID_RESET = 3'd2;
  localparam logic [2:0] ST_OFFSET_FAIL   = 3'd3;
  localparam logic [2:0] ST_SAFETY        = 3'd4;
  localparam logic [2:0] ST_DEADMAN       = 3'd5;
  localparam logic [2:0] ST_IO_MISSING    = 3'd6;

endpackage

`default_nettype wire

>>> design/robot_controller_mode_fsm_core.sv
// Supervisory mode machine of a robot controller: one event in, one result out.
//
// Usage:
//   The input channel carries one event per beat (mode plus status inputs).
//   The result channel returns one beat per event with the controller and
//   robot states after the event, a status code and one-beat action pulses.
//   The configuration port writes controller_valid and the two timeout
//   lengths; write it only while no event is in flight.
//   The result of an event is registered and valid in the cycle after the
//   event is taken. Throughput is one event per cycle unless a held result
//   stalls the input; the state update and the result are computed in one
//   pass of logic between the state registers and the result register.
//   When the receiver stalls, the result register holds its beat and the
//   input stalls only while a held result waits; an event is taken in the
//   same cycle in which the pending result leaves.
//   A synchronous reset puts the controller in init, the robot in idle,
//   clears the reset countdown, loads the run countdown with 100000 and
//   returns the configuration registers to their reset values. No result is pending.
`default_nettype none

module robot_controller_mode_fsm_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [rcmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcmf_pkg::TICKS_W-1:0]  cfg_wdata,
  // event channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_mode,
  input  wire logic [1:0]                    in_servo_status,
  input  wire logic [1:0]                    in_interp_status,
  input  wire logic [3:0]                    in_error_level,
  input  wire logic                          in_group_stopped,
  input  wire logic                          in_auto_mode,
  input  wire logic                          in_offset_ok,
  input  wire logic                          in_safety_ready,
  input  wire logic                          in_deadman_ok,
  input  wire logic                          in_io_ok,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_ctrl_now,
  output logic [2:0]                         out_robot_now,
  output logic [2:0]                         out_status,
  output logic                               out_abort_motion,
  output logic                               out_stop0_request,
  output logic                               out_clear_group,
  output logic                               out_reset_group,
  output logic                               out_power_off,
  output logic                               out_error_present
);

  // Configuration registers.
  logic                           ctrl_valid_r;
  logic [rcmf_pkg::TICKS_W-1:0]   reset_ticks_r;
  logic [rcmf_pkg::TICKS_W-1:0]   robot_ticks_r;

  // Mode state and countdowns.
  logic [2:0]                     ctrl_mode_r, ctrl_mode_nxt;
  logic [2:0]                     robot_mode_r, robot_mode_nxt;
  logic [rcmf_pkg::CNT_W-1:0]     reset_cnt_r, reset_cnt_nxt;
  logic [rcmf_pkg::CNT_W-1:0]     run_cnt_r, run_cnt_nxt;

  // Result register.
  logic                           out_valid_r;
  logic [2:0]                     ctrl_now_r, robot_now_r, status_r;
  logic                           abort_r, stop0_r, clr_r, rst_grp_r, poff_r, err_r;

  logic [2:0]                     status_nxt;
  logic                           abort_nxt, stop0_nxt, clr_nxt, rst_grp_nxt, poff_nxt;
  logic                           err;
  logic                           srv_idle, srv_run, exec;
  logic                           in_fire;
  logic [rcmf_pkg::CNT_W-1:0]     reset_dec, run_dec;

  assign in_stall   = out_valid_r & out_stall;
  assign in_fire    = in_valid & ~in_stall;

  assign err        = in_error_level >= rcmf_pkg::ERROR_LEVEL_LIMIT;
  assign srv_idle   = in_servo_status == rcmf_pkg::SRV_IDLE;
  assign srv_run    = in_servo_status == rcmf_pkg::SRV_RUN;
  assign exec       = in_interp_status == rcmf_pkg::INTERP_EXEC;
  assign reset_dec  = reset_cnt_r - 1'b1;
  assign run_dec    = run_cnt_r - 1'b1;

  always_comb begin
    ctrl_mode_nxt  = ctrl_mode_r;
    robot_mode_nxt = robot_mode_r;
    reset_cnt_nxt  = reset_cnt_r;
    run_cnt_nxt    = run_cnt_r;
    status_nxt     = rcmf_pkg::ST_OK;
    abort_nxt      = 1'b0;
    stop0_nxt      = 1'b0;
    clr_nxt        = 1'b0;
    rst_grp_nxt    = 1'b0;
    poff_nxt       = 1'b0;

    case (in_mode)
      rcmf_pkg::EV_TICK, rcmf_pkg::EV_MACRO: begin
        // A servo fault while engaged forces the controller toward estop.
        if (ctrl_mode_r == rcmf_pkg::CT_ENGAGED && !srv_idle && !srv_run) begin
          if (robot_mode_r inside {rcmf_pkg::RB_TEACHING, rcmf_pkg::RB_IDLE_TO_TEACHING,
                                   rcmf_pkg::RB_TEACHING_TO_IDLE}) begin
            clr_nxt = 1'b1;
          end
          abort_nxt     = 1'b1;
          ctrl_mode_nxt = rcmf_pkg::CT_ANY_TO_ESTOP;
        end

        // The controller step sees the robot state from before this tick.
        case (ctrl_mode_nxt)
          rcmf_pkg::CT_ANY_TO_ESTOP: begin
            if (robot_mode_r == rcmf_pkg::RB_IDLE && !srv_run) begin
              ctrl_mode_nxt = rcmf_pkg::CT_ESTOP;
            end
          end
          rcmf_pkg::CT_ESTOP_TO_ENGAGED: begin
            if (robot_mode_r == rcmf_pkg::RB_IDLE && srv_idle && !err) begin
              ctrl_mode_nxt = rcmf_pkg::CT_ENGAGED;
            end else begin
              reset_cnt_nxt = reset_dec;
              if (reset_dec[rcmf_pkg::CNT_W-1]) begin
                ctrl_mode_nxt = rcmf_pkg::CT_ESTOP;
              end
            end
          end
          rcmf_pkg::CT_ESTOP_TO_TERMINATE: begin
            if (robot_mode_r == rcmf_pkg::RB_IDLE) begin
              ctrl_mode_nxt = rcmf_pkg::CT_TERMINATED;
              poff_nxt      = 1'b1;
            end
          end
          rcmf_pkg::CT_ENGAGED: begin
            if (err) begin
              abort_nxt     = 1'b1;
              ctrl_mode_nxt = rcmf_pkg::CT_ANY_TO_ESTOP;
            end
          end
          rcmf_pkg::CT_INIT: begin
            ctrl_mode_nxt = rcmf_pkg::CT_ESTOP;
          end
          default: begin
          end
        endcase

        case (robot_mode_r)
          rcmf_pkg::RB_IDLE_TO_RUNNING: begin
            if (err) begin
              robot_mode_nxt = rcmf_pkg::RB_RUNNING_TO_IDLE;
            end else if (exec) begin
              robot_mode_nxt = rcmf_pkg::RB_RUNNING;
            end else begin
              run_cnt_nxt = run_dec;
              if (run_dec[rcmf_pkg::CNT_W-1]) begin
                robot_mode_nxt = rcmf_pkg::RB_RUNNING_TO_IDLE;
              end
            end
          end
          rcmf_pkg::RB_IDLE_TO_TEACHING: begin
            robot_mode_nxt = rcmf_pkg::RB_TEACHING;
          end
          rcmf_pkg::RB_RUNNING_TO_IDLE: begin
            if (!exec && !srv_run) begin
              run_cnt_nxt    = {1'b0, robot_ticks_r};
              robot_mode_nxt = rcmf_pkg::RB_IDLE;
            end
          end
          rcmf_pkg::RB_TEACHING_TO_IDLE: begin
            if (!srv_run) begin
              run_cnt_nxt    = {1'b0, robot_ticks_r};
              robot_mode_nxt = rcmf_pkg::RB_IDLE;
            end
          end
          rcmf_pkg::RB_RUNNING: begin
            if (!exec) begin
              robot_mode_nxt = rcmf_pkg::RB_RUNNING_TO_IDLE;
            end
          end
          rcmf_pkg::RB_TEACHING: begin
            if (in_group_stopped) begin
              robot_mode_nxt = rcmf_pkg::RB_TEACHING_TO_IDLE;
            end
          end
          default: begin
          end
        endcase

        // Macro launch looks at the states after this tick's transitions.
        if (in_mode == rcmf_pkg::EV_MACRO && in_auto_mode &&
            in_interp_status == rcmf_pkg::INTERP_IDLE &&
            ctrl_mode_nxt == rcmf_pkg::CT_ENGAGED &&
            robot_mode_nxt == rcmf_pkg::RB_IDLE) begin
          robot_mode_nxt = rcmf_pkg::RB_IDLE_TO_RUNNING;
        end
      end

      rcmf_pkg::EV_ESTOP: begin
        if (ctrl_mode_r inside {rcmf_pkg::CT_ENGAGED, rcmf_pkg::CT_ESTOP_TO_ENGAGED,
                                rcmf_pkg::CT_INIT}) begin
          stop0_nxt     = 1'b1;
          abort_nxt     = 1'b1;
          ctrl_mode_nxt = rcmf_pkg::CT_ANY_TO_ESTOP;
        end else begin
          status_nxt = rcmf_pkg::ST_INVALID_OP;
        end
      end

      rcmf_pkg::EV_RESET: begin
        if (!ctrl_valid_r) begin
          status_nxt = rcmf_pkg::ST_INVALID_RESET;
        end else if (ctrl_mode_r == rcmf_pkg::CT_ENGAGED) begin
          status_nxt = rcmf_pkg::ST_OK;
        end else if (ctrl_mode_r inside {rcmf_pkg::CT_ESTOP, rcmf_pkg::CT_INIT}) begin
          if (!in_offset_ok) begin
            abort_nxt     = 1'b1;
            ctrl_mode_nxt = rcmf_pkg::CT_ANY_TO_ESTOP;
            status_nxt    = rcmf_pkg::ST_OFFSET_FAIL;
          end else if (!in_safety_ready) begin
            status_nxt = rcmf_pkg::ST_SAFETY;
          end else if (!in_deadman_ok) begin
            status_nxt = rcmf_pkg::ST_DEADMAN;
          end else if (!in_io_ok) begin
            status_nxt = rcmf_pkg::ST_IO_MISSING;
          end else begin
            ctrl_mode_nxt = rcmf_pkg::CT_ESTOP_TO_ENGAGED;
            rst_grp_nxt   = 1'b1;
            reset_cnt_nxt = {1'b0, reset_ticks_r};
          end
        end else begin
          status_nxt = rcmf_pkg::ST_INVALID_RESET;
        end
      end

      rcmf_pkg::EV_SHUTDOWN: begin
        if (ctrl_mode_r == rcmf_pkg::CT_ESTOP) begin
          ctrl_mode_nxt = rcmf_pkg::CT_ESTOP_TO_TERMINATE;
        end else begin
          status_nxt = rcmf_pkg::ST_INVALID_OP;
        end
      end

      rcmf_pkg::EV_TEACH: begin
        if (robot_mode_r == rcmf_pkg::RB_IDLE) begin
          robot_mode_nxt = rcmf_pkg::RB_IDLE_TO_TEACHING;
        end
      end

      rcmf_pkg::EV_RUN: begin
        if (robot_mode_r == rcmf_pkg::RB_IDLE) begin
          robot_mode_nxt = rcmf_pkg::RB_IDLE_TO_RUNNING;
        end
      end

      default: begin
        status_nxt = rcmf_pkg::ST_INVALID_OP;
      end
    endcase
  end

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_valid_r  <= 1'b0;
      reset_ticks_r <= '0;
      robot_ticks_r <= rcmf_pkg::ROBOT_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcmf_pkg::CFG_CONTROLLER_VALID: ctrl_valid_r  <= cfg_wdata[0];
        rcmf_pkg::CFG_RESET_TIMEOUT:    reset_ticks_r <= cfg_wdata;
        rcmf_pkg::CFG_ROBOT_TIMEOUT:    robot_ticks_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_mode_r  <= rcmf_pkg::CT_INIT;
      robot_mode_r <= rcmf_pkg::RB_IDLE;
      reset_cnt_r  <= '0;
      run_cnt_r    <= {1'b0, rcmf_pkg::ROBOT_TIMEOUT_RESET};
    end else if (in_fire) begin
      ctrl_mode_r  <= ctrl_mode_nxt;
      robot_mode_r <= robot_mode_nxt;
      reset_cnt_r  <= reset_cnt_nxt;
      run_cnt_r    <= run_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload loads with each accepted event and holds while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctrl_now_r  <= ctrl_mode_nxt;
      robot_now_r <= robot_mode_nxt;
      status_r    <= status_nxt;
      abort_r     <= abort_nxt;
      stop0_r     <= stop0_nxt;
      clr_r       <= clr_nxt;
      rst_grp_r   <= rst_grp_nxt;
      poff_r      <= poff_nxt;
      err_r       <= err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ctrl_now      = ctrl_now_r;
  assign out_robot_now     = robot_now_r;
  assign out_status        = status_r;
  assign out_abort_motion  = abort_r;
  assign out_stop0_request = stop0_r;
  assign out_clear_group   = clr_r;
  assign out_reset_group   = rst_grp_r;
  assign out_power_off     = poff_r;
  assign out_error_present = err_r;

endmodule

`default_nettype wire
